>>> design/chh_pkg.sv
package chh_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ATAN_ITERATIONS = 16;

  localparam int AXES      = 3;
  localparam int OP_W      = 2;
  localparam int SAMPLE_W  = 16;
  localparam int OFFSET_W  = 17;
  localparam int HEADING_W = 15;

  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_AVERAGE = 2'd1;
  localparam logic [OP_W-1:0] OP_HEADING = 2'd2;

  localparam int S_DATA_W = AXES * SAMPLE_W;
  localparam int M_FIELD_W = HEADING_W + AXES * OFFSET_W;
  localparam int M_DATA_W = ((M_FIELD_W + 7) / 8) * 8;

  localparam int MAG_W       = 16;
  localparam int PRE_SHIFT   = 8;
  localparam int CORDIC_W    = 27;
  localparam int ANGLE_W     = 19;
  localparam int CLAMP_W     = 17;
  localparam int TABLE_LEN   = 24;
  localparam int TBL_W       = 5;
  localparam int ITER_W      = $clog2(ATAN_ITERATIONS);
  localparam int HALF_PI_Q16 = 102944;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Z = ANGLE_W'(HALF_PI_Q16);

  localparam int DEG_SCALE    = 5729;
  localparam int DEG_SCALE_W  = 13;
  localparam int PROD_W       = CLAMP_W + DEG_SCALE_W;
  localparam int SCALED_W     = PROD_W + ANGLE_FRAC_BITS;
  localparam int VAL_W        = SCALED_W - 16 + 1;
  localparam int ROUND_BIAS   = 50;
  localparam int DIVISOR      = 100;
  localparam int RECIP_SHIFT  = 32;
  localparam int RECIP        = 42949672;
  localparam int RECIP_W      = 26;
  localparam int QPROD_W      = VAL_W + RECIP_W;
  localparam int QUOT_W       = QPROD_W - RECIP_SHIFT;

  localparam int HDG_CALC_W = ANGLE_FRAC_BITS + 16;
  localparam logic signed [HDG_CALC_W-1:0] HDG_0   = '0;
  localparam logic signed [HDG_CALC_W-1:0] HDG_90  = HDG_CALC_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [HDG_CALC_W-1:0] HDG_180 = HDG_CALC_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [HDG_CALC_W-1:0] HDG_270 = HDG_CALC_W'(270 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic              acquire;
    logic              average;
    logic              capture;
    logic              load_diff;
    logic              init;
    logic              iterate;
    logic [ITER_W-1:0] iter;
    logic              scale;
    logic              bias;
    logic              recip;
    logic              back;
    logic              fix;
    logic              out_load;
  } chh_cmd_t;

  function automatic logic [ANGLE_W-2:0] atan_entry(input logic [TBL_W-1:0] idx);
    logic [ANGLE_W-2:0] val;
    case (idx)
      5'd0:    val = 18'd51472;
      5'd1:    val = 18'd30386;
      5'd2:    val = 18'd16055;
      5'd3:    val = 18'd8150;
      5'd4:    val = 18'd4091;
      5'd5:    val = 18'd2047;
      5'd6:    val = 18'd1024;
      5'd7:    val = 18'd512;
      5'd8:    val = 18'd256;
      5'd9:    val = 18'd128;
      5'd10:   val = 18'd64;
      5'd11:   val = 18'd32;
      5'd12:   val = 18'd16;
      5'd13:   val = 18'd8;
      5'd14:   val = 18'd4;
      5'd15:   val = 18'd2;
      5'd16:   val = 18'd1;
      default: val = 18'd0;
    endcase
    return val;
  endfunction

endpackage

>>> design/chh_ctrl.sv
module chh_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [chh_pkg::OP_W-1:0] in_op,
  output logic                   in_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  output chh_pkg::chh_cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIFF  = 4'd1;
  localparam logic [3:0] ST_INIT  = 4'd2;
  localparam logic [3:0] ST_ITER  = 4'd3;
  localparam logic [3:0] ST_SCALE = 4'd4;
  localparam logic [3:0] ST_BIAS  = 4'd5;
  localparam logic [3:0] ST_RECIP = 4'd6;
  localparam logic [3:0] ST_BACK  = 4'd7;
  localparam logic [3:0] ST_FIX   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic [chh_pkg::ITER_W-1:0] ITER_LAST =
    chh_pkg::ITER_W'(chh_pkg::ATAN_ITERATIONS - 1);

  logic [3:0]                   state;
  logic [3:0]                   state_next;
  logic [chh_pkg::ITER_W-1:0]   iter;
  logic                         accept;
  logic                         load;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state == ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    cmd           = '0;
    cmd.acquire   = accept && (in_op == chh_pkg::OP_ACQUIRE);
    cmd.average   = accept && (in_op == chh_pkg::OP_AVERAGE);
    cmd.capture   = accept && (in_op == chh_pkg::OP_HEADING);
    cmd.load_diff = (state == ST_DIFF);
    cmd.init      = (state == ST_INIT);
    cmd.iterate   = (state == ST_ITER);
    cmd.iter      = iter;
    cmd.scale     = (state == ST_SCALE);
    cmd.bias      = (state == ST_BIAS);
    cmd.recip     = (state == ST_RECIP);
    cmd.back      = (state == ST_BACK);
    cmd.fix       = (state == ST_FIX);
    cmd.out_load  = load;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (cmd.capture) state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_INIT;
      ST_INIT:  state_next = ST_ITER;
      ST_ITER:  if (iter == ITER_LAST) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_BIAS;
      ST_BIAS:  state_next = ST_RECIP;
      ST_RECIP: state_next = ST_BACK;
      ST_BACK:  state_next = ST_FIX;
      ST_FIX:   state_next = ST_OUT;
      ST_OUT:   if (load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) begin
        iter <= '0;
      end else if (state == ST_ITER) begin
        iter <= iter + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/chh_datapath.sv
module chh_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  chh_pkg::chh_cmd_t                       cmd,
  input  logic signed [chh_pkg::SAMPLE_W-1:0]     in_x,
  input  logic signed [chh_pkg::SAMPLE_W-1:0]     in_y,
  input  logic signed [chh_pkg::SAMPLE_W-1:0]     in_z,
  output logic [chh_pkg::HEADING_W-1:0]           heading,
  output logic signed [chh_pkg::OFFSET_W-1:0]     offset_x,
  output logic signed [chh_pkg::OFFSET_W-1:0]     offset_y,
  output logic signed [chh_pkg::OFFSET_W-1:0]     offset_z
);

  localparam int SW = chh_pkg::SAMPLE_W;
  localparam int OW = chh_pkg::OFFSET_W;
  localparam int CW = chh_pkg::CORDIC_W;
  localparam int AW = chh_pkg::ANGLE_W;
  localparam int HW = chh_pkg::HDG_CALC_W;

  logic signed [SW-1:0] in_s     [chh_pkg::AXES];
  logic signed [SW-1:0] axis_max [chh_pkg::AXES];
  logic signed [SW-1:0] axis_min [chh_pkg::AXES];
  logic signed [SW-1:0] axis_avg [chh_pkg::AXES];
  logic signed [SW-1:0] avg_next [chh_pkg::AXES];
  logic signed [SW-1:0] smp      [chh_pkg::AXES];
  logic signed [OW-1:0] diff     [chh_pkg::AXES];

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [AW-1:0] z;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [AW-1:0] tab;
  logic signed [OW-1:0] neg_x;
  logic signed [OW-1:0] neg_y;
  logic [chh_pkg::MAG_W-1:0] mag_x;
  logic [chh_pkg::MAG_W-1:0] mag_y;

  logic [chh_pkg::CLAMP_W-1:0]  zc;
  logic [chh_pkg::PROD_W-1:0]   prod;
  logic [chh_pkg::SCALED_W-1:0] scaled;
  logic [chh_pkg::VAL_W-1:0]    val;
  logic [chh_pkg::QPROD_W-1:0]  qprod;
  logic [chh_pkg::QUOT_W-1:0]   q0;
  logic [chh_pkg::VAL_W-1:0]    qm;
  logic [chh_pkg::VAL_W-1:0]    rem;
  logic [chh_pkg::QUOT_W-1:0]   adeg;

  logic                 x_neg;
  logic                 x_zero;
  logic                 y_neg;
  logic                 y_zero;
  logic signed [HW-1:0] t;
  logic signed [HW-1:0] hdg;

  always_comb begin
    in_s[0] = in_x;
    in_s[1] = in_y;
    in_s[2] = in_z;
    for (int i = 0; i < chh_pkg::AXES; i++) begin
      logic signed [SW:0] sum;
      sum         = {axis_max[i][SW-1], axis_max[i]} + {axis_min[i][SW-1], axis_min[i]};
      sum         = sum + {{SW{1'b0}}, sum[SW]};
      avg_next[i] = sum[SW:1];
    end
  end

  always_comb begin
    neg_x = -diff[0];
    neg_y = -diff[1];
    mag_x = diff[0][OW-1] ? neg_x[chh_pkg::MAG_W-1:0] : diff[0][chh_pkg::MAG_W-1:0];
    mag_y = diff[1][OW-1] ? neg_y[chh_pkg::MAG_W-1:0] : diff[1][chh_pkg::MAG_W-1:0];
    dx    = cy >>> cmd.iter;
    dy    = cx >>> cmd.iter;
    tab   = signed'({1'b0, chh_pkg::atan_entry(chh_pkg::TBL_W'(cmd.iter))});
    if (z[AW-1]) begin
      zc = '0;
    end else if (z > chh_pkg::HALF_PI_Z) begin
      zc = chh_pkg::CLAMP_W'(chh_pkg::HALF_PI_Q16);
    end else begin
      zc = z[chh_pkg::CLAMP_W-1:0];
    end
    scaled = chh_pkg::SCALED_W'(prod) << chh_pkg::ANGLE_FRAC_BITS;
    qprod  = chh_pkg::QPROD_W'(val) * chh_pkg::QPROD_W'(chh_pkg::RECIP);
    rem    = val - qm;
  end

  always_comb begin
    x_neg  = diff[0][OW-1];
    x_zero = (diff[0] == '0);
    y_neg  = diff[1][OW-1];
    y_zero = (diff[1] == '0);
    t      = (x_neg == y_neg) ? signed'(HW'(adeg)) : -signed'(HW'(adeg));
    if (y_zero) begin
      if (x_zero) begin
        hdg = chh_pkg::HDG_90;
      end else if (x_neg) begin
        hdg = chh_pkg::HDG_180;
      end else begin
        hdg = chh_pkg::HDG_0;
      end
    end else if (y_neg) begin
      hdg = chh_pkg::HDG_270 - t;
    end else begin
      hdg = chh_pkg::HDG_90 - t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < chh_pkg::AXES; i++) begin
        axis_max[i] <= '0;
        axis_min[i] <= '0;
        axis_avg[i] <= '0;
      end
    end else begin
      for (int i = 0; i < chh_pkg::AXES; i++) begin
        if (cmd.acquire) begin
          if (axis_max[i] == '0 && axis_min[i] == '0) begin
            axis_max[i] <= in_s[i];
            axis_min[i] <= in_s[i];
          end else if (in_s[i] > axis_max[i]) begin
            axis_max[i] <= in_s[i];
          end else if (in_s[i] < axis_min[i]) begin
            axis_min[i] <= in_s[i];
          end
        end
        if (cmd.average) begin
          axis_avg[i] <= avg_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < chh_pkg::AXES; i++) begin
      if (cmd.capture) begin
        smp[i] <= in_s[i];
      end
      if (cmd.load_diff) begin
        diff[i] <= {smp[i][SW-1], smp[i]} - {axis_avg[i][SW-1], axis_avg[i]};
      end
    end
    if (cmd.init) begin
      cx <= signed'({{(CW - chh_pkg::MAG_W - chh_pkg::PRE_SHIFT){1'b0}}, mag_y,
                     {chh_pkg::PRE_SHIFT{1'b0}}});
      cy <= signed'({{(CW - chh_pkg::MAG_W - chh_pkg::PRE_SHIFT){1'b0}}, mag_x,
                     {chh_pkg::PRE_SHIFT{1'b0}}});
      z  <= '0;
    end else if (cmd.iterate) begin
      if (!cy[CW-1]) begin
        cx <= cx + dx;
        cy <= cy - dy;
        z  <= z + tab;
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        z  <= z - tab;
      end
    end
    if (cmd.scale) begin
      prod <= chh_pkg::PROD_W'(zc) * chh_pkg::PROD_W'(chh_pkg::DEG_SCALE);
    end
    if (cmd.bias) begin
      val <= chh_pkg::VAL_W'(scaled >> 16) + chh_pkg::VAL_W'(chh_pkg::ROUND_BIAS);
    end
    if (cmd.recip) begin
      q0 <= qprod[chh_pkg::QPROD_W-1:chh_pkg::RECIP_SHIFT];
    end
    if (cmd.back) begin
      qm <= chh_pkg::VAL_W'(q0) * chh_pkg::VAL_W'(chh_pkg::DIVISOR);
    end
    if (cmd.fix) begin
      adeg <= q0 + chh_pkg::QUOT_W'(rem >= chh_pkg::VAL_W'(chh_pkg::DIVISOR));
    end
    if (cmd.out_load) begin
      heading  <= hdg[chh_pkg::HEADING_W-1:0];
      offset_x <= diff[0];
      offset_y <= diff[1];
      offset_z <= diff[2];
    end
  end

endmodule

>>> design/compass_heading_hard_iron.sv
// channel   dir  tdata (low bit up)                            tuser
// s_axis    in   sample_x[15:0] sample_y[31:16] sample_z[47:32] operation[1:0]
// m_axis    out  heading[14:0] offset_x[31:15] offset_y[48:32]
//                offset_z[65:49], zero fill to bit 71
//
// Acquire, average and unused codes complete in the accept cycle.
// A heading beat runs through two setup steps, a 16-step CORDIC loop and six
// scaling and output steps from accept to result.
// Input is stalled for the whole heading computation; the result waits in
// an output register, and the block holds in its last step until the previous result drains.
// Reset is synchronous and clears min, max and average to zero.
module compass_heading_hard_iron (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [chh_pkg::S_DATA_W-1:0]  s_axis_tdata,  // sample_x, sample_y, sample_z
  input  logic [chh_pkg::OP_W-1:0]      s_axis_tuser,  // operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [chh_pkg::M_DATA_W-1:0]  m_axis_tdata   // heading, offset_x, offset_y, offset_z
);

  chh_pkg::chh_cmd_t                      cmd;
  logic [chh_pkg::HEADING_W-1:0]          heading;
  logic signed [chh_pkg::OFFSET_W-1:0]    offset_x;
  logic signed [chh_pkg::OFFSET_W-1:0]    offset_y;
  logic signed [chh_pkg::OFFSET_W-1:0]    offset_z;

  chh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .cmd       (cmd)
  );

  chh_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_x     (s_axis_tdata[15:0]),
    .in_y     (s_axis_tdata[31:16]),
    .in_z     (s_axis_tdata[47:32]),
    .heading  (heading),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .offset_z (offset_z)
  );

  assign m_axis_tdata = {{(chh_pkg::M_DATA_W - chh_pkg::M_FIELD_W){1'b0}},
                         offset_z, offset_y, offset_x, heading};

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten while full");

  a_busy_after_heading: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == chh_pkg::OP_HEADING)
      |=> !s_axis_tready)
    else $error("input accepted during heading computation");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  a_iter_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.iterate |-> (!s_axis_tready && !cmd.out_load))
    else $error("CORDIC step overlaps accept or load");
`endif

endmodule
